### rtl/vrs_pkg.sv
package vrs_pkg;

  localparam int MAX_DIM     = 512;
  localparam int SAMPLE_BITS = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam int DIM_W      = 10;
  localparam int SAMPLE_W   = 32;
  localparam int ADDR_W     = 27;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ANGLE_W    = 16;
  localparam int DIMS_W     = 3 * DIM_W;
  localparam int COEF_W     = 18;
  localparam int TRIG_W     = 17;
  localparam int V2_W       = DIM_W + 2;
  localparam int CORDIC_W   = 34;
  localparam int PHASE_W    = 33;
  localparam int MAT_STEPS  = 15;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_X  = 3'd0,
    REG_ANGLE_Y  = 3'd1,
    REG_ANGLE_Z  = 3'd2,
    REG_SRC_DIMS = 3'd3,
    REG_DST_DIMS = 3'd4
  } reg_idx_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic signed [V2_W-1:0] v2_x;
    logic signed [V2_W-1:0] v2_y;
    logic signed [V2_W-1:0] v2_z;
    logic                   src_ok;
    logic [SAMPLE_W-1:0]    sample;
  } item_t;

  function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] d);
    return (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
  endfunction

endpackage

### rtl/vrs_if.sv
interface vrs_vox_if;
  logic                         valid;
  logic                         ready;
  logic [vrs_pkg::DIM_W-1:0]    vox_x;
  logic [vrs_pkg::DIM_W-1:0]    vox_y;
  logic [vrs_pkg::DIM_W-1:0]    vox_z;
  logic [vrs_pkg::SAMPLE_W-1:0] vox_sample;
  modport source(output valid, vox_x, vox_y, vox_z, vox_sample, input ready);
  modport sink(input valid, vox_x, vox_y, vox_z, vox_sample, output ready);
endinterface

interface vrs_dest_if;
  logic                         valid;
  logic                         ready;
  logic [vrs_pkg::ADDR_W-1:0]   dest_addr;
  logic [vrs_pkg::SAMPLE_W-1:0] dest_sample;
  logic                         dest_write;
  modport source(output valid, dest_addr, dest_sample, dest_write, input ready);
  modport sink(input valid, dest_addr, dest_sample, dest_write, output ready);
endinterface

interface vrs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [vrs_pkg::CFG_IDX_W-1:0]  index;
  logic [vrs_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/voxel_rotation_scatter.sv
// An accepted voxel is queued; the queue read feeds 5 back stages that issue its request on dest.
// Throughput: one voxel per cycle while dest.ready is high (single-issue back pipeline).
// Matrix build after reset or any angle write: three 16-step CORDIC runs plus 15
// multiply steps of three phases each; vox.ready stays low meanwhile.
// Reset: synchronous, active high; zeroes config, pointers and valid bits, starts a matrix build.
module voxel_rotation_scatter #(
  parameter int QUEUE_DEPTH = vrs_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  vrs_vox_if.sink     vox,
  vrs_dest_if.source  dest,
  vrs_cfg_if.sink     cfg
);

  logic [vrs_pkg::ANGLE_W-1:0] angle_x, angle_y, angle_z;
  logic [vrs_pkg::DIMS_W-1:0]  src_dims, dst_dims;
  logic cfg_wr, restart;
  logic mat_ready;
  vrs_pkg::coef_t coef [9];

  logic push, full, pop, q_valid;
  vrs_pkg::item_t wr_item, rd_item;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;
  assign restart   = cfg_wr && ((cfg.index == vrs_pkg::REG_ANGLE_X) ||
                                (cfg.index == vrs_pkg::REG_ANGLE_Y) ||
                                (cfg.index == vrs_pkg::REG_ANGLE_Z));

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_x  <= '0;
      angle_y  <= '0;
      angle_z  <= '0;
      src_dims <= '0;
      dst_dims <= '0;
    end else if (cfg_wr) begin
      if (cfg.index == vrs_pkg::REG_ANGLE_X) begin
        angle_x <= cfg.data[vrs_pkg::ANGLE_W-1:0];
      end
      if (cfg.index == vrs_pkg::REG_ANGLE_Y) begin
        angle_y <= cfg.data[vrs_pkg::ANGLE_W-1:0];
      end
      if (cfg.index == vrs_pkg::REG_ANGLE_Z) begin
        angle_z <= cfg.data[vrs_pkg::ANGLE_W-1:0];
      end
      if (cfg.index == vrs_pkg::REG_SRC_DIMS) begin
        src_dims <= cfg.data[vrs_pkg::DIMS_W-1:0];
      end
      if (cfg.index == vrs_pkg::REG_DST_DIMS) begin
        dst_dims <= cfg.data[vrs_pkg::DIMS_W-1:0];
      end
    end
  end

  vrs_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .angle_x   (angle_x),
    .angle_y   (angle_y),
    .angle_z   (angle_z),
    .restart   (restart),
    .mat_ready (mat_ready),
    .coef      (coef)
  );

  vrs_front u_front (
    .mat_ready (mat_ready),
    .src_dims  (src_dims),
    .full      (full),
    .vox       (vox),
    .push      (push),
    .item      (wr_item)
  );

  vrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .full    (full),
    .pop     (pop),
    .valid   (q_valid),
    .rd_item (rd_item)
  );

  vrs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (rd_item),
    .pop      (pop),
    .coef     (coef),
    .dst_dims (dst_dims),
    .dest     (dest)
  );

endmodule

### rtl/vrs_matrix.sv
module vrs_matrix (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [vrs_pkg::ANGLE_W-1:0]       angle_x,
  input  logic [vrs_pkg::ANGLE_W-1:0]       angle_y,
  input  logic [vrs_pkg::ANGLE_W-1:0]       angle_z,
  input  logic                              restart,
  output logic                              mat_ready,
  output vrs_pkg::coef_t                    coef [9]
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_ITER  = 5'b00100,
    ST_ROUND = 5'b01000,
    ST_MAT   = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    OPA_SX, OPA_CX, OPA_SY, OPA_CY, OPA_SZ, OPA_CZ, OPA_A, OPA_B
  } opa_t;

  typedef enum logic [2:0] {
    OPB_SY, OPB_CY, OPB_SZ, OPB_CZ, OPB_NEG1
  } opb_t;

  typedef enum logic [1:0] {
    RND_0, RND_15, RND_30
  } rsel_t;

  typedef struct packed {
    opa_t        a;
    opb_t        b;
    logic        sh15;
    logic        neg;
    logic        first;
    logic        last;
    rsel_t       rnd;
    logic [3:0]  entry;
    logic        st_a;
    logic        st_b;
  } mstep_t;

  localparam int ACC_W  = 52;
  localparam int PROD_W = vrs_pkg::CORDIC_W + vrs_pkg::TRIG_W;

  function automatic mstep_t mat_step(input logic [3:0] s);
    mstep_t r;
    unique case (s)
      4'd0:  r = '{OPA_SX, OPB_SY,   1'b0, 1'b0, 1'b0, 1'b0, RND_0,  4'd0, 1'b1, 1'b0};
      4'd1:  r = '{OPA_CX, OPB_SY,   1'b0, 1'b0, 1'b0, 1'b0, RND_0,  4'd0, 1'b0, 1'b1};
      4'd2:  r = '{OPA_CY, OPB_CZ,   1'b0, 1'b0, 1'b1, 1'b1, RND_15, 4'd0, 1'b0, 1'b0};
      4'd3:  r = '{OPA_CY, OPB_SZ,   1'b0, 1'b0, 1'b1, 1'b1, RND_15, 4'd1, 1'b0, 1'b0};
      4'd4:  r = '{OPA_SY, OPB_NEG1, 1'b0, 1'b0, 1'b1, 1'b1, RND_0,  4'd2, 1'b0, 1'b0};
      4'd5:  r = '{OPA_A,  OPB_CZ,   1'b0, 1'b0, 1'b1, 1'b0, RND_30, 4'd3, 1'b0, 1'b0};
      4'd6:  r = '{OPA_CX, OPB_SZ,   1'b1, 1'b1, 1'b0, 1'b1, RND_30, 4'd3, 1'b0, 1'b0};
      4'd7:  r = '{OPA_A,  OPB_SZ,   1'b0, 1'b0, 1'b1, 1'b0, RND_30, 4'd4, 1'b0, 1'b0};
      4'd8:  r = '{OPA_CX, OPB_CZ,   1'b1, 1'b0, 1'b0, 1'b1, RND_30, 4'd4, 1'b0, 1'b0};
      4'd9:  r = '{OPA_SX, OPB_CY,   1'b0, 1'b0, 1'b1, 1'b1, RND_15, 4'd5, 1'b0, 1'b0};
      4'd10: r = '{OPA_B,  OPB_CZ,   1'b0, 1'b0, 1'b1, 1'b0, RND_30, 4'd6, 1'b0, 1'b0};
      4'd11: r = '{OPA_SX, OPB_SZ,   1'b1, 1'b0, 1'b0, 1'b1, RND_30, 4'd6, 1'b0, 1'b0};
      4'd12: r = '{OPA_B,  OPB_SZ,   1'b0, 1'b0, 1'b1, 1'b0, RND_30, 4'd7, 1'b0, 1'b0};
      4'd13: r = '{OPA_SX, OPB_CZ,   1'b1, 1'b1, 1'b0, 1'b1, RND_30, 4'd7, 1'b0, 1'b0};
      4'd14: r = '{OPA_CX, OPB_CY,   1'b0, 1'b0, 1'b1, 1'b1, RND_15, 4'd8, 1'b0, 1'b0};
      default: r = '{OPA_SX, OPB_SY, 1'b0, 1'b0, 1'b0, 1'b0, RND_0, 4'd0, 1'b0, 1'b0};
    endcase
    return r;
  endfunction

  function automatic logic [31:0] atan_lut(input logic [3:0] i);
    logic [31:0] r;
    unique case (i)
      4'd0:  r = 32'h20000000;
      4'd1:  r = 32'h12E4051D;
      4'd2:  r = 32'h09FB385B;
      4'd3:  r = 32'h051111D4;
      4'd4:  r = 32'h028B0D43;
      4'd5:  r = 32'h0145D7E1;
      4'd6:  r = 32'h00A2F61E;
      4'd7:  r = 32'h00517C55;
      4'd8:  r = 32'h0028BE53;
      4'd9:  r = 32'h00145F2F;
      4'd10: r = 32'h000A2F98;
      4'd11: r = 32'h000517CC;
      4'd12: r = 32'h00028BE6;
      4'd13: r = 32'h000145F3;
      4'd14: r = 32'h0000A2FA;
      default: r = 32'h0000517D;
    endcase
    return r;
  endfunction

  // magnitude round at bit 15, optional negate, clamp to +-1.0
  function automatic logic signed [vrs_pkg::TRIG_W-1:0] trig_round(
      input logic signed [vrs_pkg::CORDIC_W-1:0] v, input logic flip);
    logic [vrs_pkg::CORDIC_W-1:0] mag;
    logic [19:0]                  r;
    logic signed [20:0]           s;
    logic signed [vrs_pkg::TRIG_W-1:0] o;
    mag = v[vrs_pkg::CORDIC_W-1] ? vrs_pkg::CORDIC_W'(-v) : vrs_pkg::CORDIC_W'(v);
    r   = 20'((mag + vrs_pkg::CORDIC_W'(16384)) >> 15);
    s   = (v[vrs_pkg::CORDIC_W-1] ^ flip) ? -$signed({1'b0, r}) : $signed({1'b0, r});
    if (s > 21'sd32768) begin
      o = 17'sd32767 + 17'sd1;
    end else if (s < -21'sd32768) begin
      o = -17'sd32768;
    end else begin
      o = 17'(s);
    end
    return o;
  endfunction

  function automatic vrs_pkg::coef_t coef_round(input logic signed [ACC_W-1:0] v,
                                                input rsel_t sel);
    logic [ACC_W-1:0]   mag;
    logic [ACC_W-1:0]   r;
    logic signed [ACC_W:0] s;
    vrs_pkg::coef_t     o;
    mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    unique case (sel)
      RND_15:  r = (mag + ACC_W'(64'd1 << 14)) >> 15;
      RND_30:  r = (mag + ACC_W'(64'd1 << 29)) >> 30;
      default: r = mag;
    endcase
    s = v[ACC_W-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    if (s > (ACC_W+1)'(32768)) begin
      o = 18'sd32768;
    end else if (s < -(ACC_W+1)'(32768)) begin
      o = -18'sd32768;
    end else begin
      o = vrs_pkg::COEF_W'(s);
    end
    return o;
  endfunction

  state_t state;
  logic [1:0] ang_sel;
  logic [3:0] iter;
  logic signed [vrs_pkg::CORDIC_W-1:0] x, y;
  logic signed [vrs_pkg::PHASE_W-1:0]  zz;
  logic flip;
  logic signed [vrs_pkg::TRIG_W-1:0] sx, cx, sy, cy, sz, cz;
  logic [3:0] step;
  logic [1:0] ph;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [vrs_pkg::CORDIC_W-1:0] ra, rb;

  mstep_t cur;
  logic [vrs_pkg::ANGLE_W-1:0] ang;
  logic [31:0] z0, zf, z_off;
  logic signed [vrs_pkg::CORDIC_W-1:0] dx, dy, opa;
  logic signed [vrs_pkg::TRIG_W-1:0] opb;
  logic signed [ACC_W-1:0] term, acc_next;
  logic [vrs_pkg::PHASE_W-1:0] atan_ext;
  logic load_flip;

  always_comb begin
    cur = mat_step(step);
    unique case (ang_sel)
      2'd0:    ang = angle_x;
      2'd1:    ang = angle_y;
      default: ang = angle_z;
    endcase
    z0 = {ang, 16'h0000};
    z_off = z0 - 32'h40000000;
    load_flip = ~z_off[31];
    zf = load_flip ? (z0 - 32'h80000000) : z0;
    dx = y >>> iter;
    dy = x >>> iter;
    atan_ext = {1'b0, atan_lut(iter)};
    unique case (cur.a)
      OPA_SX:  opa = vrs_pkg::CORDIC_W'(sx);
      OPA_CX:  opa = vrs_pkg::CORDIC_W'(cx);
      OPA_SY:  opa = vrs_pkg::CORDIC_W'(sy);
      OPA_CY:  opa = vrs_pkg::CORDIC_W'(cy);
      OPA_SZ:  opa = vrs_pkg::CORDIC_W'(sz);
      OPA_CZ:  opa = vrs_pkg::CORDIC_W'(cz);
      OPA_A:   opa = ra;
      default: opa = rb;
    endcase
    unique case (cur.b)
      OPB_SY:  opb = sy;
      OPB_CY:  opb = cy;
      OPB_SZ:  opb = sz;
      OPB_CZ:  opb = cz;
      default: opb = -17'sd1;
    endcase
    term = cur.sh15 ? $signed({prod[ACC_W-16:0], 15'b0}) : ACC_W'(prod);
    acc_next = (cur.first ? '0 : acc) + (cur.neg ? -term : term);
  end

  assign mat_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state   <= ST_LOAD;
      ang_sel <= 2'd0;
      iter    <= 4'd0;
      step    <= 4'd0;
      ph      <= 2'd0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          x     <= vrs_pkg::CORDIC_GAIN;
          y     <= '0;
          zz    <= $signed({zf[31], zf});
          flip  <= load_flip;
          iter  <= 4'd0;
          state <= ST_ITER;
        end
        ST_ITER: begin
          if (!zz[vrs_pkg::PHASE_W-1]) begin
            x  <= x - dx;
            y  <= y + dy;
            zz <= zz - $signed(atan_ext);
          end else begin
            x  <= x + dx;
            y  <= y - dy;
            zz <= zz + $signed(atan_ext);
          end
          iter <= iter + 4'd1;
          if (iter == 4'd15) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          unique case (ang_sel)
            2'd0: begin
              cx <= trig_round(x, flip);
              sx <= trig_round(y, flip);
            end
            2'd1: begin
              cy <= trig_round(x, flip);
              sy <= trig_round(y, flip);
            end
            default: begin
              cz <= trig_round(x, flip);
              sz <= trig_round(y, flip);
            end
          endcase
          if (ang_sel == 2'd2) begin
            step  <= 4'd0;
            ph    <= 2'd0;
            state <= ST_MAT;
          end else begin
            ang_sel <= ang_sel + 2'd1;
            state   <= ST_LOAD;
          end
        end
        ST_MAT: begin
          unique case (ph)
            2'd0: begin
              prod <= opa * opb;
              ph   <= 2'd1;
            end
            2'd1: begin
              if (cur.st_a) begin
                ra <= vrs_pkg::CORDIC_W'(prod);
              end
              if (cur.st_b) begin
                rb <= vrs_pkg::CORDIC_W'(prod);
              end
              if (cur.first || cur.last) begin
                acc <= acc_next;
              end
              ph <= 2'd2;
            end
            default: begin
              if (cur.last) begin
                coef[cur.entry] <= coef_round(acc, cur.rnd);
              end
              ph <= 2'd0;
              if (step == 4'(vrs_pkg::MAT_STEPS - 1)) begin
                state <= ST_IDLE;
              end else begin
                step <= step + 4'd1;
              end
            end
          endcase
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/vrs_front.sv
module vrs_front (
  input  logic                      mat_ready,
  input  logic [vrs_pkg::DIMS_W-1:0] src_dims,
  input  logic                      full,
  vrs_vox_if.sink                   vox,
  output logic                      push,
  output vrs_pkg::item_t            item
);

  logic [vrs_pkg::DIM_W-1:0] sd_x, sd_y, sd_z;

  function automatic logic signed [vrs_pkg::V2_W-1:0] center(
      input logic [vrs_pkg::DIM_W-1:0] c, input logic [vrs_pkg::DIM_W-1:0] sd);
    return $signed({1'b0, c, 1'b0}) - $signed({2'b00, sd}) + vrs_pkg::V2_W'(1);
  endfunction

  always_comb begin
    sd_x = vrs_pkg::dim_clamp(src_dims[vrs_pkg::DIM_W-1:0]);
    sd_y = vrs_pkg::dim_clamp(src_dims[2*vrs_pkg::DIM_W-1:vrs_pkg::DIM_W]);
    sd_z = vrs_pkg::dim_clamp(src_dims[3*vrs_pkg::DIM_W-1:2*vrs_pkg::DIM_W]);
    vox.ready   = mat_ready && !full;
    push        = vox.valid && vox.ready;
    item.v2_x   = center(vox.vox_x, sd_x);
    item.v2_y   = center(vox.vox_y, sd_y);
    item.v2_z   = center(vox.vox_z, sd_z);
    item.src_ok = (vox.vox_x < sd_x) && (vox.vox_y < sd_y) && (vox.vox_z < sd_z);
    item.sample = vox.vox_sample & vrs_pkg::SAMPLE_MASK;
  end

endmodule

### rtl/vrs_queue.sv
module vrs_queue #(
  parameter int DEPTH = vrs_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  vrs_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output vrs_pkg::item_t rd_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vrs_pkg::item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/vrs_back.sv
module vrs_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  vrs_pkg::item_t             q_item,
  output logic                       pop,
  input  vrs_pkg::coef_t             coef [9],
  input  logic [vrs_pkg::DIMS_W-1:0] dst_dims,
  vrs_dest_if.source                 dest
);

  localparam int P_W   = vrs_pkg::COEF_W + vrs_pkg::V2_W;
  localparam int S_W   = 32;
  localparam int N_W   = 17;
  localparam int T_W   = 2 * vrs_pkg::DIM_W;
  localparam int A_W   = 3 * vrs_pkg::DIM_W;
  localparam int DW    = vrs_pkg::DIM_W;
  localparam int V2_W_L = vrs_pkg::V2_W;

  logic [DW-1:0] od [3];
  logic en;

  logic v1, v2, v3, v4, v5;
  logic signed [P_W-1:0] p1 [9];
  logic ok1, ok2;
  logic [vrs_pkg::SAMPLE_W-1:0] smp1, smp2, smp3, smp4;
  logic signed [S_W-1:0] s2 [3];
  logic [DW-1:0] n3 [3];
  logic w3, w4;
  logic [T_W-1:0] t4;
  logic [DW-1:0] z4;

  logic signed [V2_W_L-1:0] vin [3];

  logic signed [N_W-1:0] n_c [3];
  logic in_c [3];
  logic w_c;

  function automatic logic signed [N_W-1:0] round16(input logic signed [S_W-1:0] v);
    logic [S_W-1:0] mag;
    logic [N_W-1:0] r;
    mag = v[S_W-1] ? S_W'(-v) : S_W'(v);
    r   = N_W'((mag + S_W'(32768)) >> 16);
    return v[S_W-1] ? -$signed(r) : $signed(r);
  endfunction

  always_comb begin
    od[0] = vrs_pkg::dim_clamp(dst_dims[DW-1:0]);
    od[1] = vrs_pkg::dim_clamp(dst_dims[2*DW-1:DW]);
    od[2] = vrs_pkg::dim_clamp(dst_dims[3*DW-1:2*DW]);
    vin[0] = q_item.v2_x;
    vin[1] = q_item.v2_y;
    vin[2] = q_item.v2_z;
    en  = !v5 || dest.ready;
    pop = q_valid && en;
    w_c = ok2;
    for (int r = 0; r < 3; r++) begin
      n_c[r]  = round16(s2[r]);
      in_c[r] = !n_c[r][N_W-1] && (n_c[r] < $signed({{(N_W-DW){1'b0}}, od[r]}));
      w_c     = w_c && in_c[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        p1[i] <= coef[i] * vin[i % 3];
      end
      ok1  <= q_item.src_ok;
      smp1 <= q_item.sample;

      for (int r = 0; r < 3; r++) begin
        s2[r] <= $signed({{(S_W-DW-15){1'b0}}, od[r], 15'b0}) - S_W'(32768)
                 + S_W'(p1[3*r]) + S_W'(p1[3*r+1]) + S_W'(p1[3*r+2]);
      end
      ok2  <= ok1;
      smp2 <= smp1;

      for (int r = 0; r < 3; r++) begin
        n3[r] <= w_c ? DW'(n_c[r]) : '0;
      end
      w3   <= w_c;
      smp3 <= smp2;

      t4   <= T_W'(n3[1]) + T_W'(od[1]) * T_W'(n3[0]);
      z4   <= n3[2];
      w4   <= w3;
      smp4 <= smp3;

      dest.dest_addr   <= vrs_pkg::ADDR_W'(A_W'(z4) + A_W'(od[2]) * A_W'(t4));
      dest.dest_write  <= w4;
      dest.dest_sample <= smp4;
    end
  end

  assign dest.valid = v5;

endmodule
